>>> rtl/core/duplicate_read_filter_defines.svh
// Assertion macros used by the port-level checker of the duplicate read filter.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef DUPLICATE_READ_FILTER_DEFINES_SVH
`define DUPLICATE_READ_FILTER_DEFINES_SVH

// Same-cycle implication.
`define DRF_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication.
`define DRF_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

>>> rtl/core/drf_pkg.sv
`default_nettype none

package drf_pkg;

	// Defaults of the top-level parameters
	localparam int POS_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths
	localparam int POS_W   = 16;
	localparam int THR_W   = 16;
	localparam int TOTAL_W = 32;

	// Threshold after reset
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_CLEAR = 1'b1
	} drf_op_t;

	typedef logic [TOTAL_W-1:0] drf_total_t;

	// Saturating increment of a running total
	function automatic drf_total_t sat_inc(drf_total_t v);
		return (v == '1) ? v : v + drf_total_t'(1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/drf_if.sv
`default_nettype none

// Request channel: opcode and read start position
interface drf_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] read_position;

	modport source (output valid, output opcode, output read_position, input ready);
	modport sink   (input valid, input opcode, input read_position, output ready);
endinterface

// Result channel: duplicate flag and running totals
interface drf_res_if;
	logic        valid;
	logic        ready;
	logic        is_duplicate;
	logic [31:0] unique_total;
	logic [31:0] duplicate_total;

	modport source (output valid, output is_duplicate, output unique_total,
		output duplicate_total, input ready);
	modport sink   (input valid, input is_duplicate, input unique_total,
		input duplicate_total, output ready);
endinterface

// Configuration write channel: threshold register
interface drf_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] dup_threshold;

	modport source (output valid, output dup_threshold, input ready);
	modport sink   (input valid, input dup_threshold, output ready);
endinterface

`default_nettype wire

>>> rtl/core/drf_count_mem.sv
`default_nettype none

// Per-position count store: one write port, one read port, registered read data.
module drf_count_mem
	import drf_pkg::*;
#(
	parameter int AW = POS_BITS_DEF,
	parameter int DW = COUNT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/drf_clear_ctl.sv
`default_nettype none

// Sweeps every store entry to zero, after reset and on a new-table transaction.
module drf_clear_ctl
	import drf_pkg::*;
#(
	parameter int AW = POS_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic      [AW-1:0] addr
);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	// Sweep address counter; busy out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + AW'(1);
			if (&addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

`default_nettype wire

>>> rtl/core/duplicate_read_filter.sv
// A transaction is held in stage 1, then moves to the output register once that is free.
// Throughput: one read per cycle while results are taken and no sweep runs, set by
// the single read-modify-write of the count memory; a same-position write is
// forwarded to the next read. A new-table transaction is followed by a sweep over all
// 2**POS_BITS entries. Reset: asynchronous, active low; threshold returns to 1,
// totals to zero, then the same sweep runs before the first read is taken.
`default_nettype none

module duplicate_read_filter
	import drf_pkg::*;
#(
	parameter int POS_BITS   = POS_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	drf_req_if.sink   req,
	drf_res_if.source res,
	drf_cfg_if.sink   cfg
);

	// Width for comparing a count with the threshold
	localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	logic [THR_W-1:0]      thr_q;

	logic                  valid_s1;
	drf_op_t               op_s1;
	logic [POS_BITS-1:0]   addr_s1;

	logic                  fwd_valid_q;
	logic [POS_BITS-1:0]   fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic                  out_valid_q;
	logic                  out_dup_q;
	drf_total_t            uniq_q;
	drf_total_t            dupt_q;

	logic                  req_acc;
	logic                  s1_adv;
	logic                  clr_start;
	logic                  clr_busy;
	logic [POS_BITS-1:0]   clr_addr;

	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic                  cnt_ok;
	logic                  item_wr;
	logic                  mem_wr_en;
	logic [POS_BITS-1:0]   mem_wr_addr;
	logic [COUNT_BITS-1:0] mem_wr_data;

	// Threshold register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.dup_threshold;
		end
	end

	// Handshake: stage 1 moves when the output register is free
	assign s1_adv    = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !clr_busy && !(valid_s1 && op_s1 == OP_CLEAR)
		&& (!valid_s1 || s1_adv);
	assign req_acc   = req.valid && req.ready;
	assign clr_start = s1_adv && op_s1 == OP_CLEAR;

	// Stage 1: transaction waits for its count from memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1   <= drf_op_t'(req.opcode);
			addr_s1 <= POS_BITS'(req.read_position);
		end
	end

	// Count update, with the latest write forwarded
	always_comb begin
		cur_cnt = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;
		// a zero count is a first sighting and always passes
		cnt_ok  = (cur_cnt == '0)
			|| ((CMP_W'(cur_cnt) < CMP_W'(thr_q)) && (cur_cnt != '1));
		item_wr = s1_adv && op_s1 == OP_READ && cnt_ok;
	end

	// Memory write: sweep or count update
	always_comb begin
		if (clr_busy) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_addr;
			mem_wr_data = '0;
		end else begin
			mem_wr_en   = item_wr;
			mem_wr_addr = addr_s1;
			mem_wr_data = cur_cnt + COUNT_BITS'(1);
		end
	end

	// Forwarding register holds the last count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clr_start) begin
			fwd_valid_q <= 1'b0;
		end else if (item_wr) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= mem_wr_data;
		end
	end

	// Totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_dup_q   <= 1'b0;
			uniq_q      <= '0;
			dupt_q      <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				if (op_s1 == OP_CLEAR) begin
					out_dup_q <= 1'b0;
					uniq_q    <= '0;
					dupt_q    <= '0;
				end else if (cnt_ok) begin
					out_dup_q <= 1'b0;
					uniq_q    <= sat_inc(uniq_q);
				end else begin
					out_dup_q <= 1'b1;
					dupt_q    <= sat_inc(dupt_q);
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.is_duplicate    = out_dup_q;
	assign res.unique_total    = uniq_q;
	assign res.duplicate_total = dupt_q;

	drf_count_mem #(
		.AW (POS_BITS),
		.DW (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (req_acc),
		.rd_addr (POS_BITS'(req.read_position)),
		.rd_data (rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	drf_clear_ctl #(
		.AW (POS_BITS)
	) u_clr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clr_start),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

endmodule

`default_nettype wire

>>> rtl/core/drf_checker.sv
`default_nettype none
`include "duplicate_read_filter_defines.svh"

// Port-level checks of the duplicate read filter.
module drf_checker
	import drf_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       req_opcode,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       is_duplicate,
	input wire drf_total_t unique_total,
	input wire drf_total_t duplicate_total
);

	logic       res_acc;
	drf_total_t last_u_q;
	drf_total_t last_d_q;

	assign res_acc = res_valid && res_ready;

	// Totals of the last transaction taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_u_q <= '0;
			last_d_q <= '0;
		end else if (res_acc) begin
			last_u_q <= unique_total;
			last_d_q <= duplicate_total;
		end
	end

	`DRF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(is_duplicate) && $stable(unique_total)
		&& $stable(duplicate_total), "result changed while stalled")

	`DRF_ASSERT_NEXT(a_clear_gap, req_valid && req_ready && req_opcode == OP_CLEAR,
		!req_ready, "request taken right after a new-table transaction")

	`DRF_ASSERT_NOW(a_uniq_step, res_acc && !is_duplicate,
		(unique_total == last_u_q + 32'd1 && duplicate_total == last_d_q)
		|| (unique_total == last_u_q && unique_total == '1)
		|| (unique_total == '0 && duplicate_total == '0),
		"unique total out of step")

	`DRF_ASSERT_NOW(a_dup_step, res_acc && is_duplicate,
		unique_total == last_u_q
		&& (duplicate_total == last_d_q + 32'd1
		|| (duplicate_total == last_d_q && duplicate_total == '1)),
		"duplicate total out of step")

endmodule

bind duplicate_read_filter drf_checker u_drf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.is_duplicate    (res.is_duplicate),
	.unique_total    (res.unique_total),
	.duplicate_total (res.duplicate_total)
);

`default_nettype wire

>>> tb/duplicate_read_filter_checker.sv
// Watches the request, result and threshold channels of the duplicate read filter,
// keeps its own per-position tally and compares every result with it.
module duplicate_read_filter_checker
	import drf_pkg::*;
#(
	parameter int POS_BITS   = POS_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	drf_req_if        req,
	drf_res_if        res,
	drf_cfg_if        cfg,
	output int unsigned mismatches,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	typedef struct packed {
		logic       is_dup;
		drf_total_t uniq;
		drf_total_t dups;
	} verdict_t;

	logic [THR_W-1:0]      threshold;
	logic [COUNT_BITS-1:0] hits [int unsigned];
	drf_total_t            unique_seen;
	drf_total_t            dup_seen;
	verdict_t              awaiting [$];
	verdict_t              want;

	initial mismatches = 0;
	initial pending = 0;

	task automatic report_mismatch(string what);
		mismatches++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// running totals stick at all ones
	function automatic drf_total_t step_total(drf_total_t v);
		return (v == '1) ? v : v + drf_total_t'(1);
	endfunction

	// apply one transaction to the tally and return the expected result
	function automatic verdict_t tally_read(drf_op_t op, logic [POS_W-1:0] pos);
		verdict_t              v;
		int unsigned           slot;
		logic [COUNT_BITS-1:0] seen;
		v.is_dup = 1'b0;
		if (op == OP_CLEAR) begin
			hits.delete();
			unique_seen = '0;
			dup_seen = '0;
		end else begin
			slot = 32'(pos) & ((32'd1 << POS_BITS) - 32'd1);
			seen = hits.exists(slot) ? hits[slot] : '0;
			if (seen == '0) begin
				hits[slot] = COUNT_BITS'(1);
				unique_seen = step_total(unique_seen);
			end else if (64'(seen) < 64'(threshold) && seen != COUNT_TOP) begin
				hits[slot] = seen + COUNT_BITS'(1);
				unique_seen = step_total(unique_seen);
			end else begin
				v.is_dup = 1'b1;
				dup_seen = step_total(dup_seen);
			end
		end
		v.uniq = unique_seen;
		v.dups = dup_seen;
		return v;
	endfunction

	// sample all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = THR_RESET;
			hits.delete();
			unique_seen = '0;
			dup_seen = '0;
			awaiting.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				threshold = cfg.dup_threshold;
			end
			if (res.valid && res.ready) begin
				if (awaiting.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					want = awaiting.pop_front();
					if (res.is_duplicate !== want.is_dup) begin
						report_mismatch($sformatf("is_duplicate %b, expected %b",
							res.is_duplicate, want.is_dup));
					end
					if (res.unique_total !== want.uniq) begin
						report_mismatch($sformatf("unique_total %0d, expected %0d",
							res.unique_total, want.uniq));
					end
					if (res.duplicate_total !== want.dups) begin
						report_mismatch($sformatf("duplicate_total %0d, expected %0d",
							res.duplicate_total, want.dups));
					end
				end
			end
			if (req.valid && req.ready) begin
				awaiting.push_back(tally_read(drf_op_t'(req.opcode), req.read_position));
			end
		end
		pending = awaiting.size();
	end

endmodule

>>> tb/duplicate_read_filter_tb.sv
module duplicate_read_filter_tb
	import drf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// a table clear sweeps all 2**16 entries, so the quiet limit sits well above it
	localparam int unsigned QUIET_LIMIT = 300000;
	localparam int          RAND_PHASES = 10;
	localparam int          PHASE_ITEMS = 110;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PATTERN
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	drf_req_if req_ch ();
	drf_res_if res_ch ();
	drf_cfg_if cfg_ch ();

	int unsigned mismatches;
	int unsigned pending;

	duplicate_read_filter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	duplicate_read_filter_checker tally_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result side: a new stall mode is drawn each time the current span runs out
	sink_mode_t  stall_mode = SINK_OPEN;
	int unsigned stall_span = 0;
	logic [7:0]  stall_mask = 8'h01;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= sink_mode_t'($urandom_range(0, 2));
			stall_span <= $urandom_range(16, 128);
			stall_mask <= 8'($urandom) | 8'h01;
		end else begin
			stall_span <= stall_span - 1;
			stall_mask <= {stall_mask[6:0], stall_mask[7]};
		end
		case (stall_mode)
			SINK_OPEN: begin
				res_ch.ready <= 1'b1;
			end
			SINK_RANDOM: begin
				res_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				res_ch.ready <= stall_mask[0];
			end
		endcase
	end

	// watchdog on cycles with no transaction on any channel
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("duplicate_read_filter_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// request side
	int unsigned      burst_left = 0;
	int unsigned      clears_left = 4;
	logic [POS_W-1:0] last_pos = '0;
	logic [POS_W-1:0] spot_pool [8];

	task automatic push_item(drf_op_t op, logic [POS_W-1:0] pos);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 :
				(($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5));
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.read_position <= pos;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		if (op == OP_READ) begin
			last_pos = pos;
		end
	endtask

	// stop sending and wait for every expected result
	task automatic settle();
		if (req_ch.valid) begin
			req_ch.valid <= 1'b0;
		end
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_threshold(logic [THR_W-1:0] thr);
		cfg_ch.valid <= 1'b1;
		cfg_ch.dup_threshold <= thr;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int unsigned      roll;
		logic [THR_W-1:0] thr;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_READ;
		req_ch.read_position = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.dup_threshold = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: threshold of two, repeats back to back, extreme positions
		set_threshold(16'd2);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'hFFFF);
		push_item(OP_READ, 16'hFFFF);
		push_item(OP_READ, 16'hFFFF);
		push_item(OP_READ, 16'hAAAA);
		push_item(OP_READ, 16'h5555);
		push_item(OP_READ, 16'hAAAA);
		// new table, then the same positions count from scratch
		push_item(OP_CLEAR, 16'hFFFF);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'h0000);
		push_item(OP_READ, 16'hFFFF);

		// threshold of zero: first sighting unique, then duplicates
		settle();
		set_threshold(16'd0);
		push_item(OP_READ, 16'h1234);
		push_item(OP_READ, 16'h1234);
		push_item(OP_READ, 16'h1234);
		push_item(OP_READ, 16'h0000);

		// top threshold: every read stays unique
		settle();
		set_threshold(16'hFFFF);
		push_item(OP_READ, 16'h0007);
		push_item(OP_READ, 16'h0007);
		push_item(OP_READ, 16'h0007);
		push_item(OP_READ, 16'h0007);
		push_item(OP_CLEAR, 16'h0000);

		// random phases: mostly reads from a small pool of hot positions
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			if (ph == 0) begin
				thr = 16'd1;
			end else if (ph == 1) begin
				thr = 16'hFFFF;
			end else if ($urandom_range(0, 9) < 7) begin
				thr = 16'($urandom_range(1, 6));
			end else begin
				thr = 16'($urandom_range(1, 65535));
			end
			set_threshold(thr);
			foreach (spot_pool[i]) spot_pool[i] = 16'($urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll == 0 && clears_left > 0) begin
					clears_left--;
					push_item(OP_CLEAR, 16'($urandom));
				end else if (roll < 20) begin
					push_item(OP_READ, last_pos);
				end else if (roll < 75) begin
					push_item(OP_READ, spot_pool[$urandom_range(0, 7)]);
				end else begin
					push_item(OP_READ, 16'($urandom));
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("duplicate_read_filter_tb: done, clean");
		end else begin
			$display("duplicate_read_filter_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/drf_pkg.sv
rtl/core/drf_if.sv
rtl/core/drf_count_mem.sv
rtl/core/drf_clear_ctl.sv
rtl/core/duplicate_read_filter.sv
rtl/core/drf_checker.sv
tb/duplicate_read_filter_checker.sv
tb/duplicate_read_filter_tb.sv
